// File: hw/rtl/bec_pkg.sv
// shared types and constants for the bit error counter with minimum gap
package bec_pkg;

  localparam int unsigned NUM_LANES = 8;
  localparam int unsigned POS_W     = 3;
  localparam int unsigned CNT_W     = 20;
  localparam int unsigned DIST_W    = 19;

  localparam logic [CNT_W-1:0]  CNT20_MAX = 20'hFFFFF;
  localparam logic [DIST_W-1:0] CNT19_MAX = 19'h7FFFF;
  localparam logic [3:0]        MIN_ERRORS_FOR_GAP = 4'd2;

  // what one bit lane finds
  typedef struct packed {
    logic             hit;
    logic             has_prev;
    logic [POS_W-1:0] span;
  } lane_t;

  // per-byte summary of the eight lanes
  typedef struct packed {
    logic             any;
    logic [3:0]       ecount;
    logic [POS_W-1:0] first_pos;
    logic [POS_W-1:0] last_pos;
    logic [POS_W-1:0] int_min;
  } sum_t;

  // registered item between the merge stage and the accumulator
  typedef struct packed {
    logic valid;
    logic last;
    sum_t sum;
  } stage_t;

endpackage

// File: hw/rtl/bit_error_counter_min_gap.sv
// top level of the bit error counter with minimum error gap
//
//   channel  dir  handshake            payload
//   in       in   in_valid / in_stall  ref_byte, rx_byte, last
//   out      out  out_valid / out_stall error_bits, min_distance, total_bits, all_match
//
// one byte pair per clock while in_stall is low; eight bit lanes feed a
// registered merge stage, then the accumulator updates its running counts on each
// advance, and the result register loads as the last item leaves the merge stage
// reset clears the counts and the pipeline valid flags, with no clearing pass
// in_stall rises only while a last item waits behind an unread stalled result
module bit_error_counter_min_gap
  import bec_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        ref_byte,
  input  logic [7:0]        rx_byte,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  error_bits,
  output logic [DIST_W-1:0] min_distance,
  output logic [CNT_W-1:0]  total_bits,
  output logic              all_match
);

  stage_t stage;
  logic   adv;
  logic   load;

  assign in_stall = stage.valid && !adv;
  assign load     = in_valid && !in_stall;

  bec_merge u_merge (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .adv      (adv),
    .ref_byte (ref_byte),
    .rx_byte  (rx_byte),
    .last     (last),
    .stage    (stage)
  );

  bec_accum #(.MAX_BYTES(MAX_BYTES)) u_accum (
    .clk          (clk),
    .rst          (rst),
    .stage        (stage),
    .adv          (adv),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .error_bits   (error_bits),
    .min_distance (min_distance),
    .total_bits   (total_bits),
    .all_match    (all_match)
  );

endmodule

// File: hw/rtl/bec_lane.sv
// one bit lane: mismatch flag and distance to the previous mismatch in the byte
module bec_lane
  import bec_pkg::*;
#(
  parameter int unsigned LANE = 0
) (
  input  logic [NUM_LANES-1:0] seq,
  output lane_t                res
);

  always_comb begin
    res.hit      = seq[LANE];
    res.has_prev = 1'b0;
    res.span     = '0;
    for (int j = 0; j < LANE; j++) begin
      if (seq[j]) begin
        res.has_prev = 1'b1;
        res.span     = POS_W'(LANE - j);
      end
    end
  end

endmodule

// File: hw/rtl/bec_merge.sv
// xor of the byte pair, eight bit lanes and the registered merge of their findings
module bec_merge
  import bec_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  logic       adv,
  input  logic [7:0] ref_byte,
  input  logic [7:0] rx_byte,
  input  logic       last,
  output stage_t     stage
);

  logic [NUM_LANES-1:0] seq;
  lane_t                lanes [NUM_LANES];
  sum_t                 sum_next;

  // lane 0 sees the most significant bit
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      seq[i] = ref_byte[NUM_LANES-1-i] ^ rx_byte[NUM_LANES-1-i];
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    bec_lane #(.LANE(g)) u_lane (
      .seq (seq),
      .res (lanes[g])
    );
  end

  always_comb begin
    sum_next.any       = 1'b0;
    sum_next.ecount    = '0;
    sum_next.first_pos = '0;
    sum_next.last_pos  = '0;
    sum_next.int_min   = '1;
    for (int i = NUM_LANES - 1; i >= 0; i--) begin
      if (lanes[i].hit) begin
        sum_next.first_pos = POS_W'(i);
      end
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      if (lanes[i].hit) begin
        sum_next.any      = 1'b1;
        sum_next.ecount   = sum_next.ecount + 4'd1;
        sum_next.last_pos = POS_W'(i);
        if (lanes[i].has_prev && lanes[i].span < sum_next.int_min) begin
          sum_next.int_min = lanes[i].span;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (load) begin
      stage.valid <= 1'b1;
    end else if (adv) begin
      stage.valid <= 1'b0;
    end
    if (load) begin
      stage.last <= last;
      stage.sum  <= sum_next;
    end
  end

endmodule

// File: hw/rtl/bec_accum.sv
// running counts, minimum gap and the result register
module bec_accum
  import bec_pkg::*;
#(
  parameter int unsigned MAX_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst,
  input  stage_t            stage,
  output logic              adv,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [CNT_W-1:0]  error_bits,
  output logic [DIST_W-1:0] min_distance,
  output logic [CNT_W-1:0]  total_bits,
  output logic              all_match
);

  localparam int unsigned BW = $clog2(MAX_BYTES + 1);
  localparam int unsigned TW = (BW + 3 > CNT_W) ? BW + 3 : CNT_W;

  logic [CNT_W-1:0] err_count, err_count_next;
  logic [CNT_W-1:0] gap_since_error, gap_since_error_next;
  logic [CNT_W-1:0] min_gap, min_gap_next;
  logic [BW-1:0]    byte_count, byte_count_next;

  logic             counted;
  logic [CNT_W:0]   err_sum, gap_plus8, cross_sum;
  logic [CNT_W-1:0] cross_gap, gap_sat8, min_step;
  logic             cross_ok, int_ok;
  logic [TW-1:0]    bits_wide;

  assign adv = stage.valid && !(stage.last && out_valid && out_stall);

  always_comb begin
    counted   = byte_count < BW'(MAX_BYTES);
    err_sum   = {1'b0, err_count} + (CNT_W+1)'(stage.sum.ecount);
    gap_plus8 = {1'b0, gap_since_error} + (CNT_W+1)'(8);
    cross_sum = {1'b0, gap_since_error} + (CNT_W+1)'(stage.sum.first_pos)
                + (CNT_W+1)'(1);
    cross_gap = (cross_sum > {1'b0, CNT20_MAX}) ? CNT20_MAX : cross_sum[CNT_W-1:0];
    gap_sat8  = (gap_plus8 > {1'b0, CNT20_MAX}) ? CNT20_MAX : gap_plus8[CNT_W-1:0];
    cross_ok  = stage.sum.any && (err_count != '0);
    int_ok    = stage.sum.ecount >= MIN_ERRORS_FOR_GAP;
    min_step  = (cross_ok && cross_gap < min_gap) ? cross_gap : min_gap;

    err_count_next       = err_count;
    gap_since_error_next = gap_since_error;
    min_gap_next         = min_gap;
    byte_count_next      = byte_count;
    if (counted) begin
      err_count_next  = (err_sum > {1'b0, CNT20_MAX}) ? CNT20_MAX : err_sum[CNT_W-1:0];
      byte_count_next = byte_count + BW'(1);
      min_gap_next    = (int_ok && CNT_W'(stage.sum.int_min) < min_step)
                        ? CNT_W'(stage.sum.int_min) : min_step;
      if (stage.sum.any) begin
        gap_since_error_next = CNT_W'(POS_W'(NUM_LANES - 1) - stage.sum.last_pos);
      end else begin
        gap_since_error_next = gap_sat8;
      end
    end
    bits_wide = TW'({byte_count_next, 3'b000});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      err_count       <= '0;
      gap_since_error <= '0;
      min_gap         <= CNT20_MAX;
      byte_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (adv && stage.last) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (adv) begin
        if (stage.last) begin
          err_count       <= '0;
          gap_since_error <= '0;
          min_gap         <= CNT20_MAX;
          byte_count      <= '0;
        end else begin
          err_count       <= err_count_next;
          gap_since_error <= gap_since_error_next;
          min_gap         <= min_gap_next;
          byte_count      <= byte_count_next;
        end
      end
    end
    if (adv && stage.last) begin
      error_bits <= err_count_next;
      if (err_count_next < CNT_W'(MIN_ERRORS_FOR_GAP)) begin
        min_distance <= '0;
      end else if (min_gap_next > CNT_W'(CNT19_MAX)) begin
        min_distance <= CNT19_MAX;
      end else begin
        min_distance <= min_gap_next[DIST_W-1:0];
      end
      total_bits <= (bits_wide > TW'(CNT20_MAX)) ? CNT20_MAX : bits_wide[CNT_W-1:0];
      all_match  <= (err_count_next == '0);
    end
  end

endmodule

// File: hw/rtl/bec_chk.sv
// port-level checks for the bit error counter, bound to the top level
module bec_chk
  import bec_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic [7:0]        ref_byte,
  input logic [7:0]        rx_byte,
  input logic              last,
  input logic              out_valid,
  input logic              out_stall,
  input logic [CNT_W-1:0]  error_bits,
  input logic [DIST_W-1:0] min_distance,
  input logic [CNT_W-1:0]  total_bits,
  input logic              all_match
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(ref_byte) && $stable(rx_byte)
      && $stable(last))
    else $error("stalled input item changed");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(error_bits)
      && $stable(min_distance) && $stable(total_bits) && $stable(all_match))
    else $error("stalled result changed");

  a_match_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> all_match == (error_bits == '0))
    else $error("match flag disagrees with error count");

  a_gap_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_bits < CNT_W'(MIN_ERRORS_FOR_GAP) |-> min_distance == '0)
    else $error("gap reported with fewer than two errors");

  a_err_le_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_bits <= total_bits)
    else $error("more errors than bits compared");

endmodule

bind bit_error_counter_min_gap bec_chk u_bec_chk (.*);
